// ===== hw/rtl/pcsib_pkg.sv =====
// shared types and constants for the per-category sorted index builder
package pcsib_pkg;

  localparam int MAX_JOBS_DEF  = 256;
  localparam int CAT_COUNT_DEF = 6;
  localparam int YIELD_INPUTS  = 6;
  localparam int YIELD_W       = 16;
  localparam int SCORE_W       = 15;
  localparam int ID_OUT_W      = 8;
  localparam int QCAT_W        = 3;
  localparam int QRANK_W       = 8;
  localparam int LEN_OUT_W     = 9;
  localparam int ENTRY_W       = ID_OUT_W + SCORE_W;
  localparam int IN_DATA_W     = 112;
  localparam int OUT_DATA_W    = 56;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic dispatch;
    logic cat_init;
    logic cat_next;
    logic k_init;
    logic rd_step;
    logic wr_new;
    logic wr_shift;
    logic cnt_inc;
    logic q_rd;
    logic out_load;
  } pcsib_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic ins_ok;
    logic k_zero;
    logic stop;
    logic last_cat;
    logic out_free;
  } pcsib_stat_t;

endpackage

// ===== hw/rtl/pcsib_ctrl.sv =====
// sequencing state machine for loads, queries and clears
module pcsib_ctrl
  import pcsib_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  pcsib_stat_t stat,
  output pcsib_cmd_t  cmd,
  output logic        idle
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_CAT  = 8'b0000_0100,
    S_STEP = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_NEXT = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        case (stat.op)
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end
          OP_LOAD: begin
            if (stat.full) begin
              state_nxt = S_DONE;
            end else begin
              cmd.cat_init = 1'b1;
              state_nxt    = S_CAT;
            end
          end
          OP_QUERY: begin
            cmd.q_rd  = 1'b1;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CAT: begin
        if (stat.ins_ok) begin
          cmd.k_init = 1'b1;
          state_nxt  = S_STEP;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_STEP: begin
        if (stat.k_zero) begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_NEXT;
        end else begin
          cmd.rd_step = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.stop) begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_NEXT;
        end else begin
          cmd.wr_shift = 1'b1;
          state_nxt    = S_STEP;
        end
      end
      S_NEXT: begin
        if (stat.last_cat) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cat_next = 1'b1;
          state_nxt    = S_CAT;
        end
      end
      S_FIN: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/pcsib_dp.sv =====
// datapath: item registers, list lengths, ranked entry memory and result register
module pcsib_dp
  import pcsib_pkg::*;
#(
  parameter int MAX_JOBS       = MAX_JOBS_DEF,
  parameter int CATEGORY_COUNT = CAT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcsib_cmd_t            cmd,
  output pcsib_stat_t           stat,
  input  logic [1:0]            in_op,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int LW    = $clog2(MAX_JOBS + 1);
  localparam int JW    = $clog2(MAX_JOBS);
  localparam int CW    = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
  localparam int DEPTH = CATEGORY_COUNT * MAX_JOBS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  op_t                      op_r;
  logic [YIELD_W-1:0]       yld_r [YIELD_INPUTS];
  logic [QCAT_W-1:0]        qcat_r;
  logic [QRANK_W-1:0]       qrank_r;
  logic [LW-1:0]            len_r [CATEGORY_COUNT];
  logic [LW-1:0]            cnt_r;
  logic [LW-1:0]            id_r;
  logic                     full_r;
  logic [CW-1:0]            cat_r;
  logic [JW-1:0]            k_r;
  logic [ENTRY_W-1:0]       mem [DEPTH];
  logic [ENTRY_W-1:0]       rd_data_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  // current category yield, zero for categories without an input
  logic [YIELD_W-1:0]       cur_yld;
  logic [SCORE_W-1:0]       cur_score;
  logic [LW-1:0]            cur_len;
  logic [AW-1:0]            cat_base;
  logic [AW-1:0]            q_base;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic                     q_cat_ok;
  logic [CW-1:0]            q_idx;
  logic [LW-1:0]            q_len;
  logic                     q_hit;
  logic [15:0]              q_rank_ext;
  logic [OUT_DATA_W-1:0]    res;

  always_comb begin
    cur_yld = '0;
    if (32'(cat_r) < YIELD_INPUTS) begin
      cur_yld = yld_r[3'(cat_r)];
    end
  end

  assign cur_score = cur_yld[SCORE_W-1:0];
  assign cur_len   = len_r[cat_r];
  assign cat_base  = AW'(cat_r) * AW'(MAX_JOBS);

  assign q_cat_ok   = (32'(qcat_r) < CATEGORY_COUNT);
  assign q_idx      = CW'(qcat_r);
  assign q_len      = q_cat_ok ? len_r[q_idx] : '0;
  assign q_hit      = q_cat_ok && (LW'(qrank_r) < q_len) && (32'(qrank_r) < MAX_JOBS);
  assign q_rank_ext = 16'(qrank_r);
  assign q_base     = AW'(q_idx) * AW'(MAX_JOBS);

  assign wr_addr = cat_base + AW'(k_r);
  assign rd_addr = cmd.q_rd ? (q_base + AW'(q_rank_ext[JW-1:0]))
                            : (cat_base + AW'(k_r - JW'(1)));

  assign stat.op       = op_r;
  assign stat.full     = (32'(cnt_r) >= MAX_JOBS);
  assign stat.ins_ok   = (cur_yld != '0) && !cur_yld[YIELD_W-1] && (32'(cur_len) < MAX_JOBS);
  assign stat.k_zero   = (k_r == '0);
  assign stat.stop     = (rd_data_r[SCORE_W-1:0] >= cur_score);
  assign stat.last_cat = (32'(cat_r) == CATEGORY_COUNT - 1);
  assign stat.out_free = !out_valid_r || out_ready;

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= op_t'(in_op);
      for (int i = 0; i < YIELD_INPUTS; i++) begin
        yld_r[i] <= in_data[i*YIELD_W +: YIELD_W];
      end
      qcat_r  <= in_data[YIELD_INPUTS*YIELD_W +: QCAT_W];
      qrank_r <= in_data[YIELD_INPUTS*YIELD_W + QCAT_W +: QRANK_W];
    end
    if (cmd.dispatch) begin
      id_r   <= cnt_r;
      full_r <= (32'(cnt_r) >= MAX_JOBS);
    end
    if (cmd.cat_init) begin
      cat_r <= '0;
    end else if (cmd.cat_next) begin
      cat_r <= cat_r + CW'(1);
    end
    if (cmd.k_init) begin
      k_r <= JW'(cur_len);
    end else if (cmd.wr_shift) begin
      k_r <= k_r - JW'(1);
    end
  end

  // list lengths and job counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < CATEGORY_COUNT; i++) begin
        len_r[i] <= '0;
      end
      cnt_r <= '0;
    end else begin
      if (cmd.wr_new) begin
        len_r[cat_r] <= cur_len + LW'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + LW'(1);
      end
    end
  end

  // ranked entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      mem[wr_addr] <= {ID_OUT_W'(id_r), cur_score};
    end else if (cmd.wr_shift) begin
      mem[wr_addr] <= rd_data_r;
    end
    if (cmd.rd_step || cmd.q_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result assembly
  always_comb begin
    res = '0;
    case (op_r)
      OP_LOAD: begin
        res[8] = full_r;
        if (!full_r) begin
          res[7:0] = ID_OUT_W'(id_r);
        end
      end
      OP_QUERY: begin
        res[9]     = q_hit;
        res[41:33] = LEN_OUT_W'(q_len);
        if (q_hit) begin
          res[17:10] = rd_data_r[ENTRY_W-1:SCORE_W];
          res[32:18] = rd_data_r[SCORE_W-1:0];
        end
      end
      default: res = '0;
    endcase
    res[50:42] = LEN_OUT_W'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/per_category_sorted_index_builder.sv =====
// top level of the per-category sorted index builder
// Keeps one ranked list per yield category (score descending, then job id
// ascending) in a single memory of CATEGORY_COUNT x MAX_JOBS entries. The
// opcode arrives on in_tuser. A clear or a query goes from dispatch straight to
// the result; a load visits every category in turn and moves down each entry
// that scores below the new job, unless the table is full. The
// insertion walks each list from its tail, one memory read and one write per
// entry, through the single read port of the entry memory. One item is worked
// on at a time; the result sits in an output register so the next item is
// taken while it waits. No clearing pass is needed after reset.
module per_category_sorted_index_builder
  import pcsib_pkg::*;
#(
  parameter int MAX_JOBS       = MAX_JOBS_DEF,
  parameter int CATEGORY_COUNT = CAT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // food_yield[15:0], production_yield[31:16], commerce_yield[47:32],
  // culture_yield[63:48], science_yield[79:64], religion_yield[95:80],
  // query_category[98:96], query_rank[106:99], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // assigned_id[7:0], table_full[8], entry_valid[9], entry_job[17:10],
  // entry_score[32:18], list_length[41:33], jobs_loaded[50:42], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  pcsib_cmd_t  cmd;
  pcsib_stat_t stat;
  logic        idle;

  // items are taken only while the sequencer is idle
  assign in_tready = idle;

  pcsib_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && idle),
    .stat    (stat),
    .cmd     (cmd),
    .idle    (idle)
  );

  pcsib_dp #(
    .MAX_JOBS       (MAX_JOBS),
    .CATEGORY_COUNT (CATEGORY_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

// ===== tb/pcsib_checker.sv =====
// checker for the per-category sorted index builder: predicts and compares results
module pcsib_checker
  import pcsib_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [8:0]  jobs_loaded;
    logic [8:0]  list_length;
    logic [14:0] entry_score;
    logic [7:0]  entry_job;
    logic        entry_valid;
    logic        table_full;
    logic [7:0]  assigned_id;
  } idx_result_t;

  logic [7:0]  rank_job [CAT_COUNT_DEF][MAX_JOBS_DEF];
  logic [14:0] rank_score [CAT_COUNT_DEF][MAX_JOBS_DEF];
  int          cat_len [CAT_COUNT_DEF];
  int          jobs_seen;
  idx_result_t expected_results[$];

  // place a job after every entry whose score is at least its own
  function automatic void place_job(int cat, int id, logic [14:0] score);
    int pos;
    pos = 0;
    if (cat_len[cat] >= MAX_JOBS_DEF) return;
    while (pos < cat_len[cat] && rank_score[cat][pos] >= score) pos++;
    for (int k = cat_len[cat]; k > pos; k--) begin
      rank_job[cat][k]   = rank_job[cat][k-1];
      rank_score[cat][k] = rank_score[cat][k-1];
    end
    rank_job[cat][pos]   = id[7:0];
    rank_score[cat][pos] = score;
    cat_len[cat]++;
  endfunction

  function automatic idx_result_t predict_result(logic [1:0] op, logic [IN_DATA_W-1:0] d);
    idx_result_t r;
    logic [15:0] y;
    int cat;
    int rank;
    r = '0;
    case (op_t'(op))
      OP_CLEAR: begin
        foreach (cat_len[c]) cat_len[c] = 0;
        jobs_seen = 0;
      end
      OP_LOAD: begin
        if (jobs_seen >= MAX_JOBS_DEF) begin
          r.table_full = 1'b1;
        end else begin
          for (int c = 0; c < CAT_COUNT_DEF; c++) begin
            y = d[c*16 +: 16];
            if (y != 0 && !y[15]) place_job(c, jobs_seen, y[14:0]);
          end
          r.assigned_id = jobs_seen[7:0];
          jobs_seen++;
        end
      end
      OP_QUERY: begin
        cat  = d[98:96];
        rank = d[106:99];
        if (cat < CAT_COUNT_DEF) begin
          r.list_length = cat_len[cat][8:0];
          if (rank < cat_len[cat]) begin
            r.entry_valid = 1'b1;
            r.entry_job   = rank_job[cat][rank];
            r.entry_score = rank_score[cat][rank];
          end
        end
      end
      default: ;
    endcase
    r.jobs_loaded = jobs_seen[8:0];
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    idx_result_t got;
    idx_result_t want;
    if (!rst_n) begin
      foreach (cat_len[c]) cat_len[c] = 0;
      jobs_seen  = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_result(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[50:0];
        if (out_tdata[OUT_DATA_W-1:51] != 0) begin
          $error("pad: expected 0 actual %0h", out_tdata[OUT_DATA_W-1:51]);
          fail_count++;
        end
        if (expected_results.size() == 0) begin
          $error("unexpected result item %0h", out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.assigned_id != want.assigned_id) begin
            $error("assigned_id: expected %0d actual %0d", want.assigned_id, got.assigned_id);
            fail_count++;
          end
          if (got.table_full != want.table_full) begin
            $error("table_full: expected %0d actual %0d", want.table_full, got.table_full);
            fail_count++;
          end
          if (got.entry_valid != want.entry_valid) begin
            $error("entry_valid: expected %0d actual %0d", want.entry_valid, got.entry_valid);
            fail_count++;
          end
          if (got.entry_job != want.entry_job) begin
            $error("entry_job: expected %0d actual %0d", want.entry_job, got.entry_job);
            fail_count++;
          end
          if (got.entry_score != want.entry_score) begin
            $error("entry_score: expected %0d actual %0d", want.entry_score, got.entry_score);
            fail_count++;
          end
          if (got.list_length != want.list_length) begin
            $error("list_length: expected %0d actual %0d", want.list_length, got.list_length);
            fail_count++;
          end
          if (got.jobs_loaded != want.jobs_loaded) begin
            $error("jobs_loaded: expected %0d actual %0d", want.jobs_loaded, got.jobs_loaded);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_per_category_sorted_index_builder.sv =====
// testbench top for the per-category sorted index builder: stimulus and verdict
module tb_per_category_sorted_index_builder;
  import pcsib_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = OP_NONE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count;
  int                    pending_count;
  int                    cycle_count = 0;
  // set once the receiver has finished a long hold-off
  logic                  hold_off = 1'b0;
  logic                  hold_req = 1'b0;

  localparam int CYCLE_LIMIT = 10_000_000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  per_category_sorted_index_builder i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  pcsib_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending_count
  );

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stalls, plus long hold-offs while hold_req is set
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off <= 1'b1;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  bit use_gaps = 1'b1;

  task automatic send_item(op_t op, logic [IN_DATA_W-1:0] d);
    int g;
    g = use_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [IN_DATA_W-1:0] yield_word(int mode);
    logic [IN_DATA_W-1:0] d;
    logic [15:0] y;
    d = '0;
    for (int c = 0; c < 6; c++) begin
      case (mode)
        // small positive scores force many ties
        0: y = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(1, 8));
        default: y = 16'($urandom_range(0, 65535));
      endcase
      d[c*16 +: 16] = y;
    end
    d[106:96] = 11'($urandom_range(0, 2047));
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] query_word(int cat, int rank);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    for (int c = 0; c < 6; c++) d[c*16 +: 16] = 16'($urandom_range(0, 65535));
    d[98:96]  = cat[2:0];
    d[106:99] = rank[7:0];
    return d;
  endfunction

  // let the checker record the last accepted item before looking at the count
  task automatic wait_idle();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [IN_DATA_W-1:0] d;
    int p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, ties, bad category, unused opcode
    send_item(OP_QUERY, query_word(0, 0));
    send_item(OP_QUERY, query_word(7, 255));
    d = '0;
    d[15:0] = 16'h7fff; d[31:16] = 16'h8000; d[47:32] = 16'h0001;
    d[63:48] = 16'hffff; d[79:64] = 16'h0000; d[95:80] = 16'h7fff;
    send_item(OP_LOAD, d);
    d[15:0] = 16'h0001; d[47:32] = 16'h0001; d[95:80] = 16'h7fff;
    send_item(OP_LOAD, d);
    d = '1;
    send_item(OP_LOAD, d);
    d = '0;
    for (int c = 0; c < 6; c++) d[c*16 +: 16] = 16'h0005;
    send_item(OP_LOAD, d);
    for (int c = 0; c < 6; c++) send_item(OP_QUERY, query_word(c, 0));
    send_item(OP_QUERY, query_word(0, 1));
    send_item(OP_QUERY, query_word(2, 2));
    send_item(OP_QUERY, query_word(5, 3));
    send_item(OP_QUERY, query_word(6, 0));
    send_item(OP_NONE, '1);
    send_item(OP_CLEAR, '1);
    send_item(OP_QUERY, query_word(0, 0));

    // fill the table to the limit, then loads past it are rejected
    use_gaps = 1'b0;
    for (int i = 0; i < 258; i++) send_item(OP_LOAD, yield_word(i % 2));
    use_gaps = 1'b1;
    send_item(OP_QUERY, query_word(3, 255));
    send_item(OP_QUERY, query_word(1, 0));

    // long receiver hold-off while queries keep coming
    hold_req <= 1'b1;
    for (int i = 0; i < 8; i++) send_item(OP_QUERY, query_word(i % 6, $urandom_range(0, 255)));
    hold_req <= 1'b0;
    @(posedge clk iff hold_off);

    // random mix: clears, loads, queries into the lists and unused opcodes
    for (int n = 0; n < 300; ) begin
      p = $urandom_range(0, 99);
      if (p < 5) begin
        send_item(OP_CLEAR, yield_word(1)); n++;
      end else if (p < 40) begin
        send_item(OP_LOAD, yield_word($urandom_range(0, 1))); n++;
      end else if (p < 95) begin
        send_item(OP_QUERY, query_word($urandom_range(0, 7),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                            : $urandom_range(0, 20))); n++;
      end else begin
        send_item(OP_NONE, yield_word(1)); n++;
      end
    end
    in_tvalid <= 1'b0;

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
